// ===== rtl/ps2_mouse_packet_cursor_top_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef PS2_MOUSE_PACKET_CURSOR_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define PS2MPC_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define PS2MPC_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ps2mpc_pkg.sv =====
package ps2mpc_pkg;

  localparam int COORD_BITS_DEFAULT = 13;
  localparam int MAX_COORD_BITS     = 16;
  localparam int SIZE_BITS          = 14;
  localparam int CFG_IDX_BITS       = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 14'd1024;
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 14'd768;

  // Overflow bits in the first packet byte
  localparam logic [7:0] OVF_Y = 8'h80;
  localparam logic [7:0] OVF_X = 8'h40;

  // Position of the next aux byte inside its packet
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } byte_pos_t;

  typedef struct packed {
    logic left;
    logic right;
    logic middle;
    logic dropped;
  } ps2mpc_flags_t;

  // Largest legal coordinate for a screen size, saturated at cmax.
  function automatic logic [MAX_COORD_BITS-1:0] axis_limit(
    input logic [SIZE_BITS-1:0]      size,
    input logic [MAX_COORD_BITS-1:0] cmax
  );
    logic [MAX_COORD_BITS-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else begin
      lim = MAX_COORD_BITS'(size - 14'd1);
    end
    if (lim > cmax) begin
      lim = cmax;
    end
    return lim;
  endfunction

endpackage

// ===== rtl/ps2mpc_cfg.sv =====
module ps2mpc_cfg #(
  parameter int COORD_BITS = ps2mpc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [ps2mpc_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [ps2mpc_pkg::SIZE_BITS-1:0]     wr_data,
  output logic [COORD_BITS-1:0]                lim_x,
  output logic [COORD_BITS-1:0]                lim_y
);
  import ps2mpc_pkg::*;

  localparam logic [MAX_COORD_BITS-1:0] CoordMax =
    MAX_COORD_BITS'((32'd1 << COORD_BITS) - 32'd1);

  logic [COORD_BITS-1:0]     lim_x_r, lim_x_nxt;
  logic [COORD_BITS-1:0]     lim_y_r, lim_y_nxt;
  logic [MAX_COORD_BITS-1:0] new_lim;
  logic [MAX_COORD_BITS-1:0] rst_lim_x;
  logic [MAX_COORD_BITS-1:0] rst_lim_y;

  // Limits are kept pre-decremented and saturated so the datapath only compares.
  always_comb begin
    new_lim   = axis_limit(wr_data, CoordMax);
    rst_lim_x = axis_limit(RESET_WIDTH, CoordMax);
    rst_lim_y = axis_limit(RESET_HEIGHT, CoordMax);
    lim_x_nxt = lim_x_r;
    lim_y_nxt = lim_y_r;
    if (wr_en) begin
      case (wr_index)
        REG_SCREEN_WIDTH:  lim_x_nxt = new_lim[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: lim_y_nxt = new_lim[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r <= rst_lim_x[COORD_BITS-1:0];
      lim_y_r <= rst_lim_y[COORD_BITS-1:0];
    end else begin
      lim_x_r <= lim_x_nxt;
      lim_y_r <= lim_y_nxt;
    end
  end

  assign lim_x = lim_x_r;
  assign lim_y = lim_y_r;

endmodule

// ===== rtl/ps2mpc_core.sv =====
module ps2mpc_core #(
  parameter int COORD_BITS = ps2mpc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [7:0]                data_byte,
  input  logic                      from_aux,
  input  logic [COORD_BITS-1:0]     lim_x,
  input  logic [COORD_BITS-1:0]     lim_y,
  output logic                      has_result,
  output logic [COORD_BITS-1:0]     res_x,
  output logic [COORD_BITS-1:0]     res_y,
  output ps2mpc_pkg::ps2mpc_flags_t res_flags
);
  import ps2mpc_pkg::*;

  localparam int SW = COORD_BITS + 2;

  byte_pos_t             pos_r, pos_nxt;
  logic [7:0]            first_byte_r, first_byte_nxt;
  logic [7:0]            second_byte_r, second_byte_nxt;
  logic [COORD_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r, pos_y_nxt;
  logic [2:0]            buttons_r, buttons_nxt;

  logic                  third;
  logic                  ovf;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  logic [COORD_BITS-1:0] clamp_x;
  logic [COORD_BITS-1:0] clamp_y;

  assign third = from_aux && (pos_r == POS_THIRD);
  assign ovf   = (first_byte_r & (OVF_X | OVF_Y)) != 8'h00;

  // Signed deltas: X is added, Y is subtracted (screen y grows downward).
  always_comb begin
    sum_x = $signed({2'b00, pos_x_r}) + SW'($signed(second_byte_r));
    sum_y = $signed({2'b00, pos_y_r}) - SW'($signed(data_byte));
    if (sum_x[SW-1]) begin
      clamp_x = '0;
    end else if (sum_x[SW-2:0] > {1'b0, lim_x}) begin
      clamp_x = lim_x;
    end else begin
      clamp_x = sum_x[COORD_BITS-1:0];
    end
    if (sum_y[SW-1]) begin
      clamp_y = '0;
    end else if (sum_y[SW-2:0] > {1'b0, lim_y}) begin
      clamp_y = lim_y;
    end else begin
      clamp_y = sum_y[COORD_BITS-1:0];
    end
  end

  always_comb begin
    pos_nxt         = pos_r;
    first_byte_nxt  = first_byte_r;
    second_byte_nxt = second_byte_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    buttons_nxt     = buttons_r;
    if (go && from_aux) begin
      case (pos_r)
        POS_SECOND: begin
          second_byte_nxt = data_byte;
          pos_nxt         = POS_THIRD;
        end
        POS_THIRD: begin
          pos_nxt = POS_FIRST;
          if (!ovf) begin
            buttons_nxt = first_byte_r[2:0];
            pos_x_nxt   = clamp_x;
            pos_y_nxt   = clamp_y;
          end
        end
        default: begin
          first_byte_nxt = data_byte;
          pos_nxt        = POS_SECOND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= POS_FIRST;
      first_byte_r  <= '0;
      second_byte_r <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      buttons_r     <= '0;
    end else begin
      pos_r         <= pos_nxt;
      first_byte_r  <= first_byte_nxt;
      second_byte_r <= second_byte_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      buttons_r     <= buttons_nxt;
    end
  end

  // Result as seen after this packet.
  assign has_result        = third;
  assign res_x             = ovf ? pos_x_r : clamp_x;
  assign res_y             = ovf ? pos_y_r : clamp_y;
  assign res_flags.left    = ovf ? buttons_r[0] : first_byte_r[0];
  assign res_flags.right   = ovf ? buttons_r[1] : first_byte_r[1];
  assign res_flags.middle  = ovf ? buttons_r[2] : first_byte_r[2];
  assign res_flags.dropped = ovf;

endmodule

// ===== rtl/ps2_mouse_packet_cursor_top.sv =====
// Channel | Direction | Handshake          | Beat carries
// in      | input     | in_valid/in_stall  | data_byte, from_aux
// out     | output    | out_valid/out_stall| cursor_x/y, three buttons, packet_dropped
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data (screen width/height)
//
// One input beat per cycle sustained while in_stall is low; a result beat is
// offered once the third aux byte of a packet has passed the input register
// and then the result register, with the cursor add/clamp between the two.
// Synchronous active-low reset clears the byte counter, cursor, buttons and
// both valid flags; limits return to 1024 x 768.
// in_stall rises only when a packet-ending beat waits in the input register
// while the result register is full and stalled; non-aux and non-final bytes
// keep flowing. cfg_ready is always high.
module ps2_mouse_packet_cursor_top #(
  parameter int COORD_BITS = ps2mpc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_from_aux,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [COORD_BITS-1:0]               out_cursor_x,
  output logic [COORD_BITS-1:0]               out_cursor_y,
  output logic                                out_button_left,
  output logic                                out_button_right,
  output logic                                out_button_middle,
  output logic                                out_packet_dropped,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ps2mpc_pkg::SIZE_BITS-1:0]    cfg_data
);
  import ps2mpc_pkg::*;

  // input register stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic                  s1_aux_r;
  logic                  in_accept;
  logic                  s1_go;

  // result register stage
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  ps2mpc_flags_t         out_flags_r;
  logic                  out_load;

  logic [COORD_BITS-1:0] lim_x;
  logic [COORD_BITS-1:0] lim_y;
  logic                  has_result;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  ps2mpc_flags_t         res_flags;

  assign cfg_ready = 1'b1;

  ps2mpc_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .lim_x    (lim_x),
    .lim_y    (lim_y)
  );

  ps2mpc_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .data_byte  (s1_byte_r),
    .from_aux   (s1_aux_r),
    .lim_x      (lim_x),
    .lim_y      (lim_y),
    .has_result (has_result),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_flags  (res_flags)
  );

  // A held beat moves on unless it ends a packet and the result slot is
  // full and stalled.
  assign s1_go     = s1_valid_r && (!has_result || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = s1_go && has_result;

  always_comb begin
    s1_valid_nxt = in_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_aux_r  <= in_from_aux;
    end
    if (out_load) begin
      out_x_r     <= res_x;
      out_y_r     <= res_y;
      out_flags_r <= res_flags;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_x       = out_x_r;
  assign out_cursor_y       = out_y_r;
  assign out_button_left    = out_flags_r.left;
  assign out_button_right   = out_flags_r.right;
  assign out_button_middle  = out_flags_r.middle;
  assign out_packet_dropped = out_flags_r.dropped;

endmodule

// ===== rtl/ps2mpc_checker.sv =====
`include "ps2_mouse_packet_cursor_top_macros.svh"

module ps2mpc_checker #(
  parameter int COORD_BITS = ps2mpc_pkg::COORD_BITS_DEFAULT
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [7:0]                          in_data_byte,
  input logic                                in_from_aux,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [COORD_BITS-1:0]               out_cursor_x,
  input logic [COORD_BITS-1:0]               out_cursor_y,
  input logic                                out_button_left,
  input logic                                out_button_right,
  input logic                                out_button_middle,
  input logic                                out_packet_dropped,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [ps2mpc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [ps2mpc_pkg::SIZE_BITS-1:0]    cfg_data
);

  // A stalled result beat keeps its cursor, dropped flag and left button.
  `PS2MPC_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && out_stall, $stable(out_cursor_x) && $stable(out_cursor_y) && $stable(out_packet_dropped) && $stable(out_button_left), "result payload changed while stalled")

  // Input back-pressure only comes from a full, stalled result slot.
  `PS2MPC_ASSERT_SAME(a_stall_cause, clk, !rst_n, in_stall, out_valid && out_stall, "in_stall without a blocked result")

  // A fresh result beat needs a prior accepted input beat.
  `PS2MPC_ASSERT_SAME(a_out_origin, clk, !rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without a prior input beat")

  // Reset empties the result slot.
  `PS2MPC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid, "out_valid high right after reset")

endmodule

bind ps2_mouse_packet_cursor_top ps2mpc_checker #(.COORD_BITS(COORD_BITS)) u_ps2mpc_checker (.*);
